// ===== rtl/smi_pkg.sv =====
// Shared widths, register indexes and configuration codes of the matrix invariants block.
`default_nettype none
package smi_pkg;
  localparam int ELEM_W   = 32;
  localparam int PAIR_W   = 64;
  localparam int TRIPLE_W = 96;
  localparam int SQ_W     = 66;
  localparam int ROOT_W   = 53;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int ADDR_W   = 3;
  localparam int CFG_W    = 32;
  localparam int DIM_W    = 2;
  localparam logic [0:0]       REG_DIMENSION = 1'b0;
  localparam logic [DIM_W-1:0] DIM_2X2       = 2'd2;
  localparam logic [DIM_W-1:0] DIM_RESET     = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/smi_if.sv =====
// Valid/ready channel interfaces for matrix beats and result beats.
`default_nettype none
interface smi_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface smi_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] trace_sum;
  logic signed [63:0] second_invariant;
  logic signed [63:0] determinant;
  logic [62:0] frobenius_norm;
  logic [62:0] column_sum_norm;
  logic [62:0] row_sum_norm;
  modport source(output valid, trace_sum, second_invariant, determinant, frobenius_norm,
                 column_sum_norm, row_sum_norm, input ready);
  modport sink(input valid, trace_sum, second_invariant, determinant, frobenius_norm,
               column_sum_norm, row_sum_norm, output ready);
endinterface
`default_nettype wire

// ===== rtl/small_matrix_invariants_norms.sv =====
// Top level: trace, invariants, determinant and norms of a 3x3 or 2x2 Q16.16 matrix.
// Channels: in_ch carries one matrix per beat (nine signed Q16.16 elements), out_ch
// carries one result beat per matrix (trace, second invariant, determinant, Frobenius
// norm, 1-norm, infinity-norm, all Q32.32). Beats move when valid and ready are high.
// The APB port holds the dimension register at byte address 0: 2 selects the top-left
// 2x2 block, any other value the full matrix. Write it only while the block is empty.
// Throughput: one matrix per cycle while the receiver is not stalling. From the accepting
// edge to result valid a matrix passes the input register, square stage and sum stage,
// the 53-stage square root pipeline, then the output register. Six triple-product lanes
// run side by side for the determinant and merge registers combine them.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops in the same cycle; no result is lost or repeated.
// Reset empties the pipeline, clears out_ch.valid and sets the dimension to 3.
`default_nettype none
module small_matrix_invariants_norms (
  input  logic clk,
  input  logic rst_n,
  smi_in_if.sink    in_ch,
  smi_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [smi_pkg::ADDR_W-1:0] paddr,
  input  logic [smi_pkg::CFG_W-1:0]  pwdata,
  output logic [smi_pkg::CFG_W-1:0]  prdata,
  output logic pready
);
  import smi_pkg::*;

  localparam int PIPE_N = 3 + ROOT_W;
  localparam int SIDE_N = PIPE_N - 6;
  localparam int NLANE  = 6;
  localparam int LX [NLANE] = '{0, 1, 2, 2, 0, 1};
  localparam int LY [NLANE] = '{4, 5, 3, 4, 5, 3};
  localparam int LZ [NLANE] = '{8, 6, 7, 6, 7, 8};
  localparam logic [8:0] OUTER_MASK = 9'b111100100;

  typedef struct packed {
    logic signed [63:0] trace;
    logic signed [63:0] inv2;
    logic signed [63:0] det;
    logic [62:0]        cmax;
    logic [62:0]        rmax;
  } side_t;

  function automatic logic [ELEM_W-1:0] abs_e(input logic signed [ELEM_W-1:0] v);
    return v[ELEM_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [32:0] max3(input logic [32:0] a, input logic [32:0] b,
                                       input logic [32:0] c);
    logic [32:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [98:0] v);
    logic fits;
    fits = (v[98:63] == '0) || (v[98:63] == '1);
    if (fits) return v[63:0];
    else if (v[98]) return {1'b1, 63'b0};
    else return {1'b0, {63{1'b1}}};
  endfunction

  logic [DIM_W-1:0] dim_r;
  logic             adv;
  logic [PIPE_N-1:0] v_r;
  logic             out_valid_r;

  logic signed [ELEM_W-1:0] elem [9];
  logic signed [ELEM_W-1:0] e1_r [9];
  logic signed [ELEM_W-1:0] e1_nxt [9];
  logic d2_1_r, d2_2_r, d2_3_r, d2_4_r, d2_5_r, d2_6_r;

  logic signed [PAIR_W-1:0]   xy   [NLANE];
  logic signed [TRIPLE_W-1:0] prod [NLANE];

  logic signed [PAIR_W-1:0] q_r [4], q_nxt [4];
  logic [PAIR_W-1:0]        sqv_r [9], sqv_nxt [9];
  logic signed [33:0]       tr2_r, tr2_nxt, tr3_r, tr4_r, tr5_r, tr6_r;
  logic [32:0]              cs2_r [3], rs2_r [3], cs2_nxt [3], rs2_nxt [3];

  logic signed [66:0] i2_3_r, i2_nxt;
  logic signed [64:0] det2_3_r, det2_nxt;
  logic [SQ_W-1:0]    sq3_r, sq_nxt;
  logic [32:0]        cmax3_r, rmax3_r, cmax4_r, rmax4_r, cmax5_r, rmax5_r;
  logic [32:0]        cmax6_r, rmax6_r;
  logic signed [63:0] i2_4_r, i2_5_r, i2_6_r, det2_4_r, det2_5_r, det2_6_r;
  logic signed [97:0] pos5_r, neg5_r;
  logic signed [98:0] dd6_r, dd_nxt;
  side_t              side_r [SIDE_N];
  side_t              side_nxt;
  logic [ROOT_W-1:0]  root;

  logic signed [63:0] trace_out_r, inv2_out_r, det_out_r;
  logic [62:0]        frob_out_r, cmax_out_r, rmax_out_r;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_DIMENSION) ? CFG_W'(dim_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_DIMENSION) begin
      dim_r <= pwdata[DIM_W-1:0];
    end
  end

  // pipeline control: advance unless a result waits on a stalled receiver
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[PIPE_N-2:0], in_ch.valid};
      out_valid_r <= v_r[PIPE_N-1];
    end
  end

  assign elem[0] = in_ch.a00;
  assign elem[1] = in_ch.a01;
  assign elem[2] = in_ch.a02;
  assign elem[3] = in_ch.a10;
  assign elem[4] = in_ch.a11;
  assign elem[5] = in_ch.a12;
  assign elem[6] = in_ch.a20;
  assign elem[7] = in_ch.a21;
  assign elem[8] = in_ch.a22;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e1_nxt[i] = (dim_r == DIM_2X2 && OUTER_MASK[i]) ? '0 : elem[i];
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    smi_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .x      (e1_r[LX[l]]),
      .y      (e1_r[LY[l]]),
      .z      (e1_r[LZ[l]]),
      .xy_o   (xy[l]),
      .prod_o (prod[l])
    );
  end

  smi_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  ({{(RAD_W-SQ_W-32){1'b0}}, sq3_r, 32'b0}),
    .root_o (root)
  );

  always_comb begin
    q_nxt[0] = e1_r[0] * e1_r[8];
    q_nxt[1] = e1_r[2] * e1_r[6];
    q_nxt[2] = e1_r[4] * e1_r[8];
    q_nxt[3] = e1_r[5] * e1_r[7];
    for (int i = 0; i < 9; i++) begin
      sqv_nxt[i] = e1_r[i] * e1_r[i];
    end
    tr2_nxt = 34'(e1_r[0]) + 34'(e1_r[4]) + 34'(e1_r[8]);
    for (int c = 0; c < 3; c++) begin
      cs2_nxt[c] = 33'(abs_e(e1_r[c])) + 33'(abs_e(e1_r[3+c])) + 33'(abs_e(e1_r[6+c]));
      rs2_nxt[c] = 33'(abs_e(e1_r[3*c])) + 33'(abs_e(e1_r[3*c+1]))
                 + 33'(abs_e(e1_r[3*c+2]));
    end
  end

  always_comb begin
    i2_nxt   = 67'(xy[0]) - 67'(xy[5]) + 67'(q_r[0]) - 67'(q_r[1])
             + 67'(q_r[2]) - 67'(q_r[3]);
    det2_nxt = 65'(xy[0]) - 65'(xy[5]);
    sq_nxt   = '0;
    for (int i = 0; i < 9; i++) begin
      sq_nxt = sq_nxt + SQ_W'(sqv_r[i]);
    end
  end

  always_comb begin
    dd_nxt         = 99'(pos5_r) - 99'(neg5_r);
    side_nxt.trace = {{14{tr6_r[33]}}, tr6_r, 16'b0};
    side_nxt.inv2  = i2_6_r;
    side_nxt.det   = d2_6_r ? det2_6_r : sat64(dd6_r >>> 16);
    side_nxt.cmax  = {14'b0, cmax6_r, 16'b0};
    side_nxt.rmax  = {14'b0, rmax6_r, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r     <= e1_nxt;
      d2_1_r   <= (dim_r == DIM_2X2);
      q_r      <= q_nxt;
      sqv_r    <= sqv_nxt;
      tr2_r    <= tr2_nxt;
      cs2_r    <= cs2_nxt;
      rs2_r    <= rs2_nxt;
      d2_2_r   <= d2_1_r;
      i2_3_r   <= i2_nxt;
      det2_3_r <= det2_nxt;
      sq3_r    <= sq_nxt;
      tr3_r    <= tr2_r;
      cmax3_r  <= max3(cs2_r[0], cs2_r[1], cs2_r[2]);
      rmax3_r  <= max3(rs2_r[0], rs2_r[1], rs2_r[2]);
      d2_3_r   <= d2_2_r;
      i2_4_r   <= sat64(99'(i2_3_r));
      det2_4_r <= sat64(99'(det2_3_r));
      tr4_r    <= tr3_r;
      cmax4_r  <= cmax3_r;
      rmax4_r  <= rmax3_r;
      d2_4_r   <= d2_3_r;
      pos5_r   <= 98'(prod[0]) + 98'(prod[1]) + 98'(prod[2]);
      neg5_r   <= 98'(prod[3]) + 98'(prod[4]) + 98'(prod[5]);
      i2_5_r   <= i2_4_r;
      det2_5_r <= det2_4_r;
      tr5_r    <= tr4_r;
      cmax5_r  <= cmax4_r;
      rmax5_r  <= rmax4_r;
      d2_5_r   <= d2_4_r;
      dd6_r    <= dd_nxt;
      i2_6_r   <= i2_5_r;
      det2_6_r <= det2_5_r;
      tr6_r    <= tr5_r;
      cmax6_r  <= cmax5_r;
      rmax6_r  <= rmax5_r;
      d2_6_r   <= d2_5_r;
      side_r[0] <= side_nxt;
      for (int k = 1; k < SIDE_N; k++) begin
        side_r[k] <= side_r[k-1];
      end
      trace_out_r <= side_r[SIDE_N-1].trace;
      inv2_out_r  <= side_r[SIDE_N-1].inv2;
      det_out_r   <= side_r[SIDE_N-1].det;
      frob_out_r  <= 63'(root);
      cmax_out_r  <= side_r[SIDE_N-1].cmax;
      rmax_out_r  <= side_r[SIDE_N-1].rmax;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.trace_sum        = trace_out_r;
  assign out_ch.second_invariant = inv2_out_r;
  assign out_ch.determinant      = det_out_r;
  assign out_ch.frobenius_norm   = frob_out_r;
  assign out_ch.column_sum_norm  = cmax_out_r;
  assign out_ch.row_sum_norm     = rmax_out_r;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted beat did not enter the pipeline");
  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input blocked without an output stall");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(v_r))
    else $error("pipeline moved during an output stall");
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.frobenius_norm[62:ROOT_W] == '0))
    else $error("square root wider than its pipeline");
`endif
endmodule
`default_nettype wire

// ===== rtl/smi_lane.sv =====
// Triple product lane: x*y, then split product with z, then recombine.
`default_nettype none
module smi_lane (
  input  logic clk,
  input  logic en,
  input  logic signed [smi_pkg::ELEM_W-1:0]   x,
  input  logic signed [smi_pkg::ELEM_W-1:0]   y,
  input  logic signed [smi_pkg::ELEM_W-1:0]   z,
  output logic signed [smi_pkg::PAIR_W-1:0]   xy_o,
  output logic signed [smi_pkg::TRIPLE_W-1:0] prod_o
);
  import smi_pkg::*;

  logic signed [PAIR_W-1:0]   xy_r, xy_nxt;
  logic signed [ELEM_W-1:0]   z_r;
  logic signed [PAIR_W:0]     plo_r, plo_nxt;
  logic signed [PAIR_W-1:0]   phi_r, phi_nxt;
  logic signed [TRIPLE_W-1:0] prod_r, prod_nxt;

  always_comb begin
    xy_nxt   = x * y;
    plo_nxt  = $signed({1'b0, xy_r[ELEM_W-1:0]}) * z_r;
    phi_nxt  = $signed(xy_r[PAIR_W-1:ELEM_W]) * z_r;
    prod_nxt = (TRIPLE_W'(phi_r) <<< ELEM_W) + TRIPLE_W'(plo_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xy_r   <= xy_nxt;
      z_r    <= z;
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign xy_o   = xy_r;
  assign prod_o = prod_r;
endmodule
`default_nettype wire

// ===== rtl/smi_sqrt.sv =====
// Pipelined restoring square root, one root bit per stage.
`default_nettype none
module smi_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [smi_pkg::RAD_W-1:0]  rad_i,
  output logic [smi_pkg::ROOT_W-1:0] root_o
);
  import smi_pkg::*;
  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_p, rem_nxt;
    logic [ROOT_W-1:0] root_p, root_nxt;
    logic [RAD_W-1:0]  rad_p, rad_nxt;
    logic [REM_W+1:0]  cand, trial, diff;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
    end

    always_comb begin
      cand    = {rem_p, rad_p[RAD_W-1 -: 2]};
      trial   = {{(REM_W-ROOT_W){1'b0}}, root_p, 2'b01};
      diff    = cand - trial;
      rad_nxt = {rad_p[RAD_W-3:0], 2'b00};
      if (cand >= trial) begin
        rem_nxt  = diff[REM_W-1:0];
        root_nxt = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cand[REM_W-1:0];
        root_nxt = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_nxt;
      end
    end
  end

  assign root_o = root_r[ROOT_W-1];
endmodule
`default_nettype wire

// ===== verif/small_matrix_invariants_norms_test.sv =====
// Testbench: directed and random matrices checked field by field against known results or a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module small_matrix_invariants_norms_test;
  import smi_pkg::*;

  typedef struct {
    logic signed [31:0] e [9];
  } matrix_t;

  typedef struct {
    logic signed [63:0] tr;
    logic signed [63:0] i2;
    logic signed [63:0] det;
    logic [62:0] fro;
    logic [62:0] col;
    logic [62:0] row;
  } invariants_t;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_BEATS = 450;
  localparam logic signed [31:0] MAXE = 32'sh7fffffff;
  localparam logic signed [31:0] MINE = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  smi_in_if in_ch ();
  smi_out_if out_ch ();

  small_matrix_invariants_norms u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [DIM_W-1:0] dim_model;
  invariants_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic signed [127:0] clamp64(input logic signed [127:0] v);
    if (v > 128'sh7fffffffffffffff) return 128'sh7fffffffffffffff;
    if (v < -128'sh8000000000000000) return -128'sh8000000000000000;
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 52; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic invariants_t compute_invariants(input matrix_t m, input logic [DIM_W-1:0] d);
    logic signed [127:0] a [3][3];
    logic signed [127:0] tr, i2, det, p;
    logic [127:0] sq, cs, rs, cmax, rmax, ab;
    int n;
    invariants_t r;
    n = (d == DIM_2X2) ? 2 : 3;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = m.e[i*3+j];
    tr = 0; i2 = 0; sq = 0; cmax = 0; rmax = 0;
    for (int i = 0; i < n; i++) begin
      cs = 0; rs = 0;
      tr += a[i][i];
      for (int j = 0; j < n; j++) begin
        cs += (a[j][i] < 0) ? -a[j][i] : a[j][i];
        ab = (a[i][j] < 0) ? -a[i][j] : a[i][j];
        rs += ab;
        sq += ab * ab;
      end
      if (cs > cmax) cmax = cs;
      if (rs > rmax) rmax = rs;
    end
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) i2 += a[i][i]*a[j][j] - a[i][j]*a[j][i];
    if (n == 2) begin
      det = a[0][0]*a[1][1] - a[1][0]*a[0][1];
    end else begin
      p = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
        - a[0][2]*a[1][1]*a[2][0] - a[0][0]*a[1][2]*a[2][1] - a[0][1]*a[1][0]*a[2][2];
      det = p >>> 16;
    end
    r.tr = 64'(tr <<< 16);
    r.i2 = 64'(clamp64(i2));
    r.det = 64'(clamp64(det));
    r.fro = 63'(floor_sqrt(sq << 32));
    r.col = 63'(cmax << 16);
    r.row = 63'(rmax << 16);
    return r;
  endfunction

  task automatic write_dimension(input logic [DIM_W-1:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_DIMENSION) << 2; pwdata <= CFG_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dim_model = v;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_matrix(input matrix_t m, input bit has_known, input invariants_t known);
    invariants_t exp_r;
    int gap;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.a00, in_ch.a01, in_ch.a02} <= {m.e[0], m.e[1], m.e[2]};
    {in_ch.a10, in_ch.a11, in_ch.a12} <= {m.e[3], m.e[4], m.e[5]};
    {in_ch.a20, in_ch.a21, in_ch.a22} <= {m.e[6], m.e[7], m.e[8]};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_r = has_known ? known : compute_invariants(m, dim_model);
    expected_q.push_back(exp_r);
  endtask

  function automatic matrix_t random_matrix();
    matrix_t m;
    for (int k = 0; k < 9; k++)
      case ($urandom_range(0, 5))
        0: m.e[k] = MAXE;
        1: m.e[k] = MINE;
        2: m.e[k] = $signed($urandom_range(0, 8)) * ONE - 4 * ONE;
        3: m.e[k] = $signed(32'($urandom_range(0, 511))) - 256;
        default: m.e[k] = $urandom();
      endcase
    return m;
  endfunction

  // Directed table: matrices plus expected results where obvious.
  typedef struct {
    logic [DIM_W-1:0] dim;
    matrix_t m;
    bit known;
    invariants_t r;
  } vector_t;

  vector_t directed [$];

  task automatic build_directed();
    vector_t v;
    invariants_t z;
    z = '{default: '0};
    v.known = 1'b1; v.r = z; v.dim = DIM_RESET;
    v.m.e = '{default: 32'sd0};
    directed.push_back(v);
    v.m.e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    v.r = '{64'sh3_0000_0000, 64'sh3_0000_0000, 64'sh1_0000_0000,
            63'h1_BB67_AE85, 63'h1_0000_0000, 63'h1_0000_0000};
    directed.push_back(v);
    v.known = 1'b0;
    v.m.e = '{default: MAXE}; directed.push_back(v);
    v.m.e = '{default: MINE}; directed.push_back(v);
    v.m.e = '{MAXE, MINE, MAXE, MINE, MAXE, MINE, MAXE, MINE, MAXE}; directed.push_back(v);
    v.m.e = '{MINE, MAXE, MINE, MINE, MINE, MAXE, MAXE, MINE, MINE}; directed.push_back(v);
    v.m.e = '{-1, 1, -1, 1, -1, 1, -1, 1, -1}; directed.push_back(v);
    v.m.e = '{3, 0, 0, 0, 5, 0, 0, 0, 7}; directed.push_back(v);
    v.dim = DIM_2X2;
    v.m.e = '{MAXE, MINE, MAXE, MINE, MAXE, MINE, MAXE, MINE, MAXE}; directed.push_back(v);
    v.m.e = '{MINE, MAXE, 7, MAXE, MINE, 9, 1, 2, 3}; directed.push_back(v);
    v.m.e = '{ONE, 2*ONE, MAXE, 3*ONE, 4*ONE, MINE, MAXE, MINE, MAXE}; directed.push_back(v);
    v.dim = 2'd0;
    v.m.e = '{ONE, 2, 3, 4, ONE, 6, 7, 8, ONE}; directed.push_back(v);
    v.dim = 2'd1;
    v.m.e = '{ONE, 2, 3, 4, ONE, 6, 7, 8, ONE}; directed.push_back(v);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat");
      end else begin
        invariants_t e;
        e = expected_q.pop_front();
        if (out_ch.trace_sum !== e.tr || out_ch.second_invariant !== e.i2 ||
            out_ch.determinant !== e.det || out_ch.frobenius_norm !== e.fro ||
            out_ch.column_sum_norm !== e.col || out_ch.row_sum_norm !== e.row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h %h %h got %h %h %h %h %h %h",
                     e.tr, e.i2, e.det, e.fro, e.col, e.row,
                     out_ch.trace_sum, out_ch.second_invariant, out_ch.determinant,
                     out_ch.frobenius_norm, out_ch.column_sum_norm, out_ch.row_sum_norm);
        end
      end
    end
  end

  // Receiver stalls
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.ready && out_ch.valid) begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (wait_n != 0) begin
          out_ch.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else if (!stim_done || expected_q.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("small_matrix_invariants_norms_test failed");
      $finish;
    end
  end

  initial begin
    logic [DIM_W-1:0] cur_dim;
    invariants_t none;
    in_ch.valid = 1'b0;
    {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
     in_ch.a20, in_ch.a21, in_ch.a22} = '0;
    dim_model = DIM_RESET;
    none = '{default: '0};
    build_directed();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_dim = DIM_RESET;
    foreach (directed[k]) begin
      if (directed[k].dim != cur_dim) begin
        drain();
        write_dimension(directed[k].dim);
        cur_dim = directed[k].dim;
      end
      send_matrix(directed[k].m, directed[k].known, directed[k].r);
    end
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_dimension(ph == 5 ? DIM_RESET : DIM_W'($urandom_range(0, 3)));
      for (int k = 0; k < RANDOM_BEATS / 6; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          matrix_t m;
          m = random_matrix();
          in_ch.valid <= 1'b1;
          {in_ch.a00, in_ch.a01, in_ch.a02} <= {m.e[0], m.e[1], m.e[2]};
          {in_ch.a10, in_ch.a11, in_ch.a12} <= {m.e[3], m.e[4], m.e[5]};
          {in_ch.a20, in_ch.a21, in_ch.a22} <= {m.e[6], m.e[7], m.e[8]};
          @(posedge clk);
          while (!in_ch.ready) @(posedge clk);
          expected_q.push_back(compute_invariants(m, dim_model));
        end else begin
          send_matrix(random_matrix(), 1'b0, none);
        end
      end
    end
    stim_done = 1'b1;
    drain();
    if (mismatches == 0)
      $display("small_matrix_invariants_norms_test passed");
    else
      $display("small_matrix_invariants_norms_test failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/smi_pkg.sv
rtl/smi_if.sv
rtl/smi_lane.sv
rtl/smi_sqrt.sv
rtl/small_matrix_invariants_norms.sv
verif/small_matrix_invariants_norms_test.sv
